/* rtl/core/baro_temp_pressure_compensation_macros.svh */
// Assertion macros shared by the compensation block.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define BTPC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BTPC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/btpc_pkg.sv */
// Shared types, constants and helper functions for the compensation block.
`default_nettype none

package btpc_pkg;

    localparam int DATA_W    = 32;
    localparam int RAW_W     = 19;
    localparam int HALF_W    = 16;
    localparam int OSS_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_CNT_W = $clog2(DATA_W);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AC1_AC2 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AC3_AC4 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AC5_AC6 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B1_B2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MC_MD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OSS     = 3'd5;

    localparam logic [OSS_W-1:0] OSS_RESET = 2'd3;

    // Word kinds
    localparam logic KIND_TEMP  = 1'b0;
    localparam logic KIND_PRESS = 1'b1;

    // Compensation constants
    localparam logic [DATA_W-1:0] C_B6_OFS = 32'd4000;
    localparam logic [DATA_W-1:0] C_B4_OFS = 32'd32768;
    localparam logic [DATA_W-1:0] C_PSCALE = 32'd50000;
    localparam logic [DATA_W-1:0] C_HALF   = 32'h8000_0000;
    localparam logic [DATA_W-1:0] C_P1     = 32'd3038;
    localparam logic [DATA_W-1:0] C_P2     = 32'd0 - 32'd7357;
    localparam logic [DATA_W-1:0] C_P3     = 32'd3791;
    localparam logic [DATA_W-1:0] C_TROUND = 32'd8;
    localparam logic [DATA_W-1:0] C_TWO    = 32'd2;

    typedef struct packed {
        logic             kind;
        logic [RAW_W-1:0] raw_value;
    } in_word_t;

    typedef struct packed {
        logic                     result_kind;
        logic signed [DATA_W-1:0] value;
        logic                     div_error;
    } out_word_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_T_MUL,
        ST_T_X1,
        ST_T_DEN,
        ST_T_DIV,
        ST_T_FIN,
        ST_P_M1,
        ST_P_M2,
        ST_P_M3,
        ST_P_M4,
        ST_P_M5,
        ST_P_M6,
        ST_P_M7,
        ST_P_M8,
        ST_P_M9,
        ST_P_DGO,
        ST_P_DIV,
        ST_P_M10,
        ST_P_M11,
        ST_P_M12,
        ST_P_FIN,
        ST_DONE
    } state_t;

    function automatic logic [DATA_W-1:0] asr32(input logic [DATA_W-1:0] v,
                                                input logic [4:0] n);
        asr32 = DATA_W'($signed(v) >>> n);
    endfunction

    function automatic logic [DATA_W-1:0] sx16(input logic [HALF_W-1:0] v);
        sx16 = {{(DATA_W-HALF_W){v[HALF_W-1]}}, v};
    endfunction

endpackage

`default_nettype wire

/* rtl/core/btpc_div.sv */
// Serial unsigned 32-bit restoring divider, one quotient bit per cycle.
`default_nettype none

module btpc_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  btpc_pkg::div_req_t req,
    output btpc_pkg::div_rsp_t rsp
);
    import btpc_pkg::*;

    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DATA_W:0]      rem_sh;
    logic [DATA_W:0]      rem_sub;

    assign rem_sh  = {rem_reg, quo_reg[DATA_W-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = DIV_CNT_W'(DATA_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // borrow out means the divisor does not fit
            if (!rem_sub[DATA_W]) begin
                rem_next = rem_sub[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

/* rtl/core/baro_temp_pressure_compensation.sv */
// Barometric temperature / pressure integer compensation, one shared multiplier + serial divider.
// A zero divisor skips the 32-step divider and yields an error word with value 0.
// One word in flight: s_ready returns in the same cycle as the result appears in the output register.
// aresetn (sync, active low): coefficients clear, oversampling = 3, stored b5 term = 0.
`default_nettype none

module baro_temp_pressure_compensation (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input words
    input  logic                                s_valid,
    output logic                                s_ready,
    input  btpc_pkg::in_word_t                  s_data,
    // result words
    output logic                                m_valid,
    input  logic                                m_ready,
    output btpc_pkg::out_word_t                 m_data,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [btpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [btpc_pkg::DATA_W-1:0]         cfg_wdata
);
    import btpc_pkg::*;

    `include "baro_temp_pressure_compensation_macros.svh"

    // ------------------------------------------------------------------
    // Calibration registers
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] ac12_reg, ac34_reg, ac56_reg, b12_reg, mcmd_reg;
    logic [OSS_W-1:0]  oss_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ac12_reg <= '0;
            ac34_reg <= '0;
            ac56_reg <= '0;
            b12_reg  <= '0;
            mcmd_reg <= '0;
            oss_reg  <= OSS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_AC1_AC2: ac12_reg <= cfg_wdata;
                CFG_AC3_AC4: ac34_reg <= cfg_wdata;
                CFG_AC5_AC6: ac56_reg <= cfg_wdata;
                CFG_B1_B2:   b12_reg  <= cfg_wdata;
                CFG_MC_MD:   mcmd_reg <= cfg_wdata;
                CFG_OSS:     oss_reg  <= cfg_wdata[OSS_W-1:0];
                default: ;   // unknown index: write dropped
            endcase
        end
    end

    // Unpacked calibration words, 32-bit two's complement; ac4, ac5, ac6 zero-extended, the rest sign-extended
    logic [DATA_W-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

    assign ac1 = sx16(ac12_reg[DATA_W-1:HALF_W]);
    assign ac2 = sx16(ac12_reg[HALF_W-1:0]);
    assign ac3 = sx16(ac34_reg[DATA_W-1:HALF_W]);
    assign ac4 = {{(DATA_W-HALF_W){1'b0}}, ac34_reg[HALF_W-1:0]};
    assign ac5 = {{(DATA_W-HALF_W){1'b0}}, ac56_reg[DATA_W-1:HALF_W]};
    assign ac6 = {{(DATA_W-HALF_W){1'b0}}, ac56_reg[HALF_W-1:0]};
    assign b1  = sx16(b12_reg[DATA_W-1:HALF_W]);
    assign b2  = sx16(b12_reg[HALF_W-1:0]);
    assign mc  = sx16(mcmd_reg[DATA_W-1:HALF_W]);
    assign md  = sx16(mcmd_reg[HALF_W-1:0]);

    // ------------------------------------------------------------------
    // Sequencer state and working registers
    //   a/b/c/d are scratch; their meaning per step is noted in the FSM.
    // ------------------------------------------------------------------
    state_t            state_reg, state_next;
    logic [DATA_W-1:0] prod_reg, prod_next;
    logic [DATA_W-1:0] a_reg, a_next;
    logic [DATA_W-1:0] b_reg, b_next;
    logic [DATA_W-1:0] c_reg, c_next;
    logic [DATA_W-1:0] d_reg, d_next;
    logic              neg_reg, neg_next;       // quotient sign / post-shift flag
    logic [DATA_W-1:0] val_reg, val_next;
    logic              err_reg, err_next;
    logic              kind_reg, kind_next;
    logic [RAW_W-1:0]  raw_reg, raw_next;
    logic [DATA_W-1:0] temp_term_reg, temp_term_next;   // b5 of last temperature word

    logic              m_valid_reg, m_valid_next;
    out_word_t         m_data_reg;
    logic              out_load;

    // Shared multiplier, low 32 bits of the product
    logic [DATA_W-1:0] mul_a, mul_b;

    assign prod_next = mul_a * mul_b;

    // Divider
    div_req_t div_req;
    div_rsp_t div_rsp;

    btpc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Small adders feeding the sequencer
    logic [DATA_W-1:0] mc_sh, den, b5_sum, t_round, b3_pre, b3_sh, b3_calc;
    logic [DATA_W-1:0] press_k, p8, raw_ext, p_quot;

    assign raw_ext = {{(DATA_W-RAW_W){1'b0}}, raw_reg};
    assign mc_sh   = mc << 11;
    assign den     = a_reg + md;
    assign b5_sum  = a_reg + b_reg;
    assign t_round = asr32(b5_sum + C_TROUND, 5'd4);
    assign b3_pre  = (ac1 << 2) + a_reg;
    assign b3_sh   = b3_pre << oss_reg;
    assign b3_calc = asr32(b3_sh + C_TWO, 5'd2);
    assign press_k = C_PSCALE >> oss_reg;
    assign p8      = asr32(c_reg, 5'd8);
    assign p_quot  = neg_reg ? (div_rsp.quotient << 1) : div_rsp.quotient;

    always_comb begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        neg_next       = neg_reg;
        val_next       = val_reg;
        err_next       = err_reg;
        kind_next      = kind_reg;
        raw_next       = raw_reg;
        temp_term_next = temp_term_reg;
        mul_a          = '0;
        mul_b          = '0;
        div_req        = '0;
        out_load       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next = s_data.kind;
                    raw_next  = s_data.raw_value;
                    err_next  = 1'b0;
                    if (s_data.kind == KIND_TEMP) begin
                        // d = raw - ac6
                        d_next     = {{(DATA_W-RAW_W){1'b0}}, s_data.raw_value} - ac6;
                        state_next = ST_T_MUL;
                    end else begin
                        // d = b6
                        d_next     = temp_term_reg - C_B6_OFS;
                        state_next = ST_P_M1;
                    end
                end
            end

            // ---------------- temperature ----------------
            ST_T_MUL: begin
                mul_a      = d_reg;
                mul_b      = ac5;
                state_next = ST_T_X1;
            end
            ST_T_X1: begin
                a_next     = asr32(prod_reg, 5'd15);    // x1
                state_next = ST_T_DEN;
            end
            ST_T_DEN: begin
                if (den == '0) begin
                    err_next       = 1'b1;
                    val_next       = '0;
                    temp_term_next = a_reg;             // b5 = x1
                    state_next     = ST_DONE;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = mc_sh[DATA_W-1] ? (32'd0 - mc_sh) : mc_sh;
                    div_req.divisor  = den[DATA_W-1] ? (32'd0 - den) : den;
                    neg_next         = mc_sh[DATA_W-1] ^ den[DATA_W-1];
                    state_next       = ST_T_DIV;
                end
            end
            ST_T_DIV: begin
                if (div_rsp.done) begin
                    b_next     = neg_reg ? (32'd0 - div_rsp.quotient) : div_rsp.quotient;
                    state_next = ST_T_FIN;
                end
            end
            ST_T_FIN: begin
                temp_term_next = b5_sum;
                val_next       = sx16(t_round[HALF_W-1:0]);
                state_next     = ST_DONE;
            end

            // ---------------- pressure ----------------
            ST_P_M1: begin
                mul_a      = d_reg;                     // b6 * b6
                mul_b      = d_reg;
                state_next = ST_P_M2;
            end
            ST_P_M2: begin
                b_next     = asr32(prod_reg, 5'd12);    // sq
                mul_a      = ac2;
                mul_b      = d_reg;
                state_next = ST_P_M3;
            end
            ST_P_M3: begin
                a_next     = asr32(prod_reg, 5'd11);    // ac2 term
                mul_a      = b_reg;
                mul_b      = b2;
                state_next = ST_P_M4;
            end
            ST_P_M4: begin
                a_next     = a_reg + asr32(prod_reg, 5'd11);   // x3
                mul_a      = ac3;
                mul_b      = d_reg;
                state_next = ST_P_M5;
            end
            ST_P_M5: begin
                c_next     = b3_calc;                   // b3
                a_next     = asr32(prod_reg, 5'd13);
                mul_a      = b1;
                mul_b      = b_reg;
                state_next = ST_P_M6;
            end
            ST_P_M6: begin
                a_next     = asr32(a_reg + asr32(prod_reg, 5'd16) + C_TWO, 5'd2);
                d_next     = raw_ext - c_reg;           // raw - b3
                state_next = ST_P_M7;
            end
            ST_P_M7: begin
                mul_a      = d_reg;
                mul_b      = press_k;
                a_next     = a_reg + C_B4_OFS;
                state_next = ST_P_M8;
            end
            ST_P_M8: begin
                d_next     = prod_reg;                  // b7
                mul_a      = ac4;
                mul_b      = a_reg;
                state_next = ST_P_M9;
            end
            ST_P_M9: begin
                c_next     = prod_reg >> 15;            // b4
                state_next = ST_P_DGO;
            end
            ST_P_DGO: begin
                if (c_reg == '0) begin
                    err_next   = 1'b1;
                    val_next   = '0;
                    state_next = ST_DONE;
                end else begin
                    // large b7: divide first, double afterwards
                    div_req.start    = 1'b1;
                    div_req.dividend = (d_reg < C_HALF) ? (d_reg << 1) : d_reg;
                    div_req.divisor  = c_reg;
                    neg_next         = !(d_reg < C_HALF);
                    state_next       = ST_P_DIV;
                end
            end
            ST_P_DIV: begin
                if (div_rsp.done) begin
                    c_next     = p_quot;                // p
                    state_next = ST_P_M10;
                end
            end
            ST_P_M10: begin
                mul_a      = p8;
                mul_b      = p8;
                state_next = ST_P_M11;
            end
            ST_P_M11: begin
                a_next     = prod_reg;
                mul_a      = c_reg;
                mul_b      = C_P2;
                state_next = ST_P_M12;
            end
            ST_P_M12: begin
                d_next     = asr32(prod_reg, 5'd16);    // x2
                mul_a      = a_reg;
                mul_b      = C_P1;
                state_next = ST_P_FIN;
            end
            ST_P_FIN: begin
                val_next   = c_reg + asr32(asr32(prod_reg, 5'd16) + d_reg + C_P3, 5'd4);
                state_next = ST_DONE;
            end

            // ---------------- hand-off ----------------
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            temp_term_reg <= '0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            temp_term_reg <= temp_term_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        d_reg    <= d_next;
        neg_reg  <= neg_next;
        val_reg  <= val_next;
        err_reg  <= err_next;
        kind_reg <= kind_next;
        raw_reg  <= raw_next;
        if (out_load) begin
            m_data_reg.result_kind <= kind_reg;
            m_data_reg.value       <= val_reg;
            m_data_reg.div_error   <= err_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BTPC_ASSERT_SAME(a_div_start_idle, aclk, aresetn, div_req.start, !div_rsp.busy, "divider restarted while busy")
    `BTPC_ASSERT_SAME(a_div_done_ctx, aclk, aresetn, div_rsp.done, state_reg == ST_T_DIV || state_reg == ST_P_DIV, "divider finished outside a divide step")
    `BTPC_ASSERT_SAME(a_err_zero, aclk, aresetn, m_valid && m_data.div_error, m_data.value == '0, "error word with nonzero value")
    `BTPC_ASSERT_NEXT(a_out_kind, aclk, aresetn, out_load, m_valid && m_data.result_kind == $past(kind_reg), "result kind does not echo the word")

endmodule

`default_nettype wire
